// ===== design/bsp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_pkg
// Shared types and constants for the bit stream packer.
// ----------------------------------------------------------------------------
package bsp_pkg;

   localparam int VALUE_W     = 32;
   localparam int COUNT_W     = 8;
   localparam int CMD_W       = 2;
   localparam int BYTE_W      = 8;
   localparam int OFF_W       = 3;
   localparam int STEP_W      = 4;
   localparam int SHIFT_W     = 6;
   localparam int VALUE_BITS  = 32;
   localparam int MAX_RUN     = 255;
   localparam int QUEUE_DEPTH = 2;

   localparam int REQ_DATA_W  = 40;
   localparam int RSP_DATA_W  = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_VALUE = 2'd0,
      CMD_RUN   = 2'd1,
      CMD_FLUSH = 2'd2,
      CMD_CLOSE = 2'd3
   } cmd_type;

   typedef enum logic {
      KIND_PUSH  = 1'b0,
      KIND_FLUSH = 1'b1
   } kind_type;

   typedef struct packed {
      kind_type             kind;
      logic                 run;
      logic                 fill;
      logic [VALUE_W-1:0]   word;
      logic [COUNT_W-1:0]   rem;
   } entry_type;

endpackage

// ===== design/bit_stream_packer_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bit_stream_packer_unit
// Packs pushed bits into bytes, bit 0 first within each byte.
// ----------------------------------------------------------------------------
// Input channel req_*: one command per transaction. tuser carries the
// command (push value, push run, flush, close); tdata carries value and
// count. Pushes with a count of zero are dropped at the input.
// Result channel rsp_*: one byte per transaction; tlast marks the final
// result of a command. A push that completes no byte gives no result; a
// flush always gives exactly one.
// Each command passes through the queue, the back end's command registers
// and the output register before its first result is valid. The back end
// places up to one byte worth of bits per cycle, and waits only when a step
// completes a byte while the output register still holds one; a command is
// stepped through byte by byte, its last bits left in the partial byte.
// A small queue decouples input from the back end; input stalls only when
// it is full. When the receiver stalls, the output register holds its
// transaction and the back end waits at its next byte. Reset empties the
// queue, clears the partial byte and bit offset and drops any pending result.
// ----------------------------------------------------------------------------
module bit_stream_packer_unit #(
   parameter int QUEUE_DEPTH = bsp_pkg::QUEUE_DEPTH
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [bsp_pkg::REQ_DATA_W-1:0]  req_tdata,   // value[31:0], count[39:32]
   input  logic [bsp_pkg::CMD_W-1:0]       req_tuser,   // cmd[1:0]
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [bsp_pkg::RSP_DATA_W-1:0]  rsp_tdata,   // data_byte[7:0], pad_bits[10:8]
   output logic                            rsp_tuser,   // byte_valid[0]
   output logic                            rsp_tlast
);

   logic                          push;
   logic                          full;
   logic                          pop;
   logic                          head_valid;
   bsp_pkg::entry_type            push_entry;
   bsp_pkg::entry_type            head_entry;
   logic [bsp_pkg::BYTE_W-1:0]    out_byte;
   logic [bsp_pkg::OFF_W-1:0]     out_pad;

   assign req_tready = !full;

   bsp_front u_front (
      .req_valid (req_tvalid),
      .req_cmd   (req_tuser),
      .req_value (req_tdata[bsp_pkg::VALUE_W-1:0]),
      .req_count (req_tdata[bsp_pkg::VALUE_W +: bsp_pkg::COUNT_W]),
      .push      (push),
      .entry     (push_entry)
   );

   bsp_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   bsp_back u_back (
      .clock          (clock),
      .reset          (reset),
      .head_valid     (head_valid),
      .head_entry     (head_entry),
      .pop            (pop),
      .out_valid      (rsp_tvalid),
      .out_ready      (rsp_tready),
      .out_byte       (out_byte),
      .out_byte_valid (rsp_tuser),
      .out_pad        (out_pad),
      .out_last       (rsp_tlast)
   );

   assign rsp_tdata = {
      {(bsp_pkg::RSP_DATA_W - bsp_pkg::BYTE_W - bsp_pkg::OFF_W){1'b0}},
      out_pad,
      out_byte
   };

endmodule

// ===== design/bsp_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_front
// Decodes an incoming transaction into a queue entry: saturates counts,
// bit-reverses value so the first bit sits in bit 0, drops empty pushes.
// ----------------------------------------------------------------------------
module bsp_front (
   input  logic                        req_valid,
   input  logic [bsp_pkg::CMD_W-1:0]   req_cmd,
   input  logic [bsp_pkg::VALUE_W-1:0] req_value,
   input  logic [bsp_pkg::COUNT_W-1:0] req_count,
   output logic                        push,
   output bsp_pkg::entry_type          entry
);

   logic [bsp_pkg::VALUE_W-1:0]   rev;
   logic [bsp_pkg::SHIFT_W-1:0]   vcnt;
   logic [bsp_pkg::SHIFT_W-1:0]   sh;
   logic [bsp_pkg::COUNT_W-1:0]   rcnt;
   logic                          is_flush;
   logic                          is_run;

   always_comb begin
      for (int i = 0; i < bsp_pkg::VALUE_W; i++) begin
         rev[i] = req_value[bsp_pkg::VALUE_W-1-i];
      end
      if (req_count > bsp_pkg::COUNT_W'(bsp_pkg::VALUE_BITS)) begin
         vcnt = bsp_pkg::SHIFT_W'(bsp_pkg::VALUE_BITS);
      end else begin
         vcnt = bsp_pkg::SHIFT_W'(req_count);
      end
      if (req_count > bsp_pkg::COUNT_W'(bsp_pkg::MAX_RUN)) begin
         rcnt = bsp_pkg::COUNT_W'(bsp_pkg::MAX_RUN);
      end else begin
         rcnt = req_count;
      end
      sh       = bsp_pkg::SHIFT_W'(bsp_pkg::VALUE_W) - vcnt;
      is_flush = 1'b0;
      is_run   = 1'b0;
      case (bsp_pkg::cmd_type'(req_cmd))
         bsp_pkg::CMD_VALUE: is_run = 1'b0;
         bsp_pkg::CMD_RUN:   is_run = 1'b1;
         default:            is_flush = 1'b1;
      endcase

      entry.kind = is_flush ? bsp_pkg::KIND_FLUSH : bsp_pkg::KIND_PUSH;
      entry.run  = is_run;
      entry.fill = (req_value != '0);
      entry.word = (sh >= bsp_pkg::SHIFT_W'(bsp_pkg::VALUE_W)) ? '0 : (rev >> sh);
      entry.rem  = is_run ? rcnt : bsp_pkg::COUNT_W'(vcnt);
      push       = req_valid && (is_flush || (entry.rem != '0));
   end

endmodule

// ===== design/bsp_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_queue
// Small FIFO of decoded entries between the front and the back.
// ----------------------------------------------------------------------------
module bsp_queue #(
   parameter int DEPTH = bsp_pkg::QUEUE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  bsp_pkg::entry_type push_entry,
   output logic               full,
   input  logic               pop,
   output logic               head_valid,
   output bsp_pkg::entry_type head_entry
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   bsp_pkg::entry_type     mem_ff [DEPTH];
   logic [PTR_W-1:0]       wr_ff, wr_in;
   logic [PTR_W-1:0]       rd_ff, rd_in;
   logic [CNT_W-1:0]       cnt_ff, cnt_in;
   logic                   do_push;
   logic                   do_pop;

   always_comb begin
      full       = (cnt_ff == CNT_W'(DEPTH));
      head_valid = (cnt_ff != '0);
      head_entry = mem_ff[rd_ff];
      do_push    = push && !full;
      do_pop     = pop && head_valid;
      wr_in      = wr_ff;
      rd_in      = rd_ff;
      if (do_push) begin
         wr_in = (wr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      cnt_in = cnt_ff + CNT_W'(do_push) - CNT_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_entry;
      end
   end

endmodule

// ===== design/bsp_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bsp_back
// Places up to one byte of bits per cycle into the partial byte, waiting while
// the result register is still full, and drives the registered result channel.
// ----------------------------------------------------------------------------
module bsp_back (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  bsp_pkg::entry_type           head_entry,
   output logic                         pop,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [bsp_pkg::BYTE_W-1:0]   out_byte,
   output logic                         out_byte_valid,
   output logic [bsp_pkg::OFF_W-1:0]    out_pad,
   output logic                         out_last
);

   logic                          busy_ff, busy_in;
   bsp_pkg::kind_type             kind_ff, kind_in;
   logic                          run_ff, run_in;
   logic                          fill_ff, fill_in;
   logic [bsp_pkg::VALUE_W-1:0]   word_ff, word_in;
   logic [bsp_pkg::COUNT_W-1:0]   rem_ff, rem_in;
   logic [bsp_pkg::BYTE_W-1:0]    part_ff, part_in;
   logic [bsp_pkg::OFF_W-1:0]     off_ff, off_in;

   logic                          ov_ff, ov_in;
   logic [bsp_pkg::BYTE_W-1:0]    ob_ff, ob_in;
   logic                          obv_ff, obv_in;
   logic [bsp_pkg::OFF_W-1:0]     opad_ff, opad_in;
   logic                          olast_ff, olast_in;

   logic                          out_free;
   logic [bsp_pkg::STEP_W-1:0]    room;
   logic [bsp_pkg::STEP_W-1:0]    k;
   logic [bsp_pkg::BYTE_W-1:0]    mask;
   logic [bsp_pkg::BYTE_W-1:0]    chunk;
   logic [bsp_pkg::BYTE_W-1:0]    merged;
   logic [bsp_pkg::STEP_W-1:0]    new_off;
   logic [bsp_pkg::COUNT_W-1:0]   rem_next;
   logic                          emit;
   logic                          fire;
   logic                          done;

   always_comb begin
      out_free = !ov_ff || out_ready;
      room     = bsp_pkg::STEP_W'(bsp_pkg::BYTE_W) - bsp_pkg::STEP_W'(off_ff);
      k        = (rem_ff < bsp_pkg::COUNT_W'(room)) ? bsp_pkg::STEP_W'(rem_ff) : room;
      mask     = bsp_pkg::BYTE_W'((9'd1 << k) - 9'd1);
      chunk    = (run_ff ? {bsp_pkg::BYTE_W{fill_ff}} : word_ff[bsp_pkg::BYTE_W-1:0]) & mask;
      merged   = part_ff | (chunk << off_ff);
      new_off  = bsp_pkg::STEP_W'(off_ff) + k;
      rem_next = rem_ff - bsp_pkg::COUNT_W'(k);

      busy_in  = busy_ff;
      kind_in  = kind_ff;
      run_in   = run_ff;
      fill_in  = fill_ff;
      word_in  = word_ff;
      rem_in   = rem_ff;
      part_in  = part_ff;
      off_in   = off_ff;
      ov_in    = ov_ff && !out_ready;
      ob_in    = ob_ff;
      obv_in   = obv_ff;
      opad_in  = opad_ff;
      olast_in = olast_ff;
      emit     = 1'b0;
      fire     = 1'b0;
      done     = 1'b0;

      if (busy_ff) begin
         case (kind_ff)
            bsp_pkg::KIND_FLUSH: begin
               emit = 1'b1;
               fire = out_free;
               done = out_free;
               if (fire) begin
                  ob_in    = part_ff;
                  obv_in   = (off_ff != '0);
                  opad_in  = (off_ff != '0) ? (3'd0 - off_ff) : '0;
                  olast_in = 1'b1;
                  part_in  = '0;
                  off_in   = '0;
               end
            end
            default: begin
               emit = new_off[bsp_pkg::STEP_W-1];
               fire = !emit || out_free;
               done = fire && (rem_next == '0);
               if (fire) begin
                  word_in = word_ff >> k;
                  rem_in  = rem_next;
                  if (emit) begin
                     ob_in    = merged;
                     obv_in   = 1'b1;
                     opad_in  = '0;
                     olast_in = (rem_next < bsp_pkg::COUNT_W'(bsp_pkg::BYTE_W));
                     part_in  = '0;
                     off_in   = '0;
                  end else begin
                     part_in  = merged;
                     off_in   = new_off[bsp_pkg::OFF_W-1:0];
                  end
               end
            end
         endcase
      end

      if (fire && emit) begin
         ov_in = 1'b1;
      end
      if (done) begin
         busy_in = 1'b0;
      end

      pop = head_valid && (!busy_ff || done);
      if (pop) begin
         busy_in = 1'b1;
         kind_in = head_entry.kind;
         run_in  = head_entry.run;
         fill_in = head_entry.fill;
         word_in = head_entry.word;
         rem_in  = head_entry.rem;
      end

      out_valid      = ov_ff;
      out_byte       = ob_ff;
      out_byte_valid = obv_ff;
      out_pad        = opad_ff;
      out_last       = olast_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         ov_ff   <= 1'b0;
         part_ff <= '0;
         off_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         ov_ff   <= ov_in;
         part_ff <= part_in;
         off_ff  <= off_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff  <= kind_in;
      run_ff   <= run_in;
      fill_ff  <= fill_in;
      word_ff  <= word_in;
      rem_ff   <= rem_in;
      ob_ff    <= ob_in;
      obv_ff   <= obv_in;
      opad_ff  <= opad_in;
      olast_ff <= olast_in;
   end

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for bit_stream_packer_unit.
// ----------------------------------------------------------------------------
// Drives commands on the req_* stream and predicts every byte on the rsp_*
// stream. A tracker class keeps its own partial byte and bit offset and
// queues the expected bytes as each command transaction is accepted. Each
// result transaction is checked field by field against the oldest one.
// A directed set covers empty and padded flushes, close, zero and saturated
// counts, and long runs. A random set of about 330 commands follows. Both
// sides idle in short random bursts, and the receiver holds off once for a
// long stretch so that the input stalls. A watchdog ends a run that hangs.
// ----------------------------------------------------------------------------
module tb;
   import bsp_pkg::*;

   localparam int RANDOM_COMMANDS = 330;
   localparam int LONG_HOLD       = 300;
   localparam int DRAIN_CYCLES    = 16;
   localparam int WATCHDOG_LIMIT  = 2000;

   typedef struct {
      logic [BYTE_W-1:0] data_byte;
      logic              byte_valid;
      logic [OFF_W-1:0]  pad_bits;
      logic              is_last;
   } packed_byte_type;

   class packed_byte_tracker;
      packed_byte_type   pending_bytes[$];
      logic [BYTE_W-1:0] partial;
      logic [OFF_W-1:0]  offset;
      int                errors;

      function new();
         partial = '0;
         offset  = '0;
         errors  = 0;
      endfunction

      function void place_bit(logic b);
         if (b) begin
            partial[offset] = 1'b1;
         end
         offset = offset + 1'b1;
         if (offset == '0) begin
            pending_bytes.push_back('{data_byte: partial, byte_valid: 1'b1,
                                      pad_bits: '0, is_last: 1'b0});
            partial = '0;
         end
      endfunction

      function void note_command(cmd_type cmd, logic [VALUE_W-1:0] value,
                                 logic [COUNT_W-1:0] count);
         int n;
         int queued;
         queued = pending_bytes.size();
         case (cmd)
            CMD_VALUE: begin
               n = (count > VALUE_BITS) ? VALUE_BITS : int'(count);
               for (int i = n - 1; i >= 0; i--) begin
                  place_bit(value[i]);
               end
            end
            CMD_RUN: begin
               n = (count > MAX_RUN) ? MAX_RUN : int'(count);
               for (int i = 0; i < n; i++) begin
                  place_bit(value != '0);
               end
            end
            default: begin
               if (offset == '0) begin
                  pending_bytes.push_back('{data_byte: '0, byte_valid: 1'b0,
                                            pad_bits: '0, is_last: 1'b1});
               end else begin
                  pending_bytes.push_back('{data_byte: partial, byte_valid: 1'b1,
                                            pad_bits: 3'(4'd8 - {1'b0, offset}),
                                            is_last: 1'b1});
                  partial = '0;
                  offset  = '0;
               end
            end
         endcase
         if (pending_bytes.size() > queued) begin
            pending_bytes[pending_bytes.size() - 1].is_last = 1'b1;
         end
      endfunction

      function void compare_field(string field, int expected, int actual);
         if (expected != actual) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h",
                     $time, field, expected, actual);
            errors++;
         end
      endfunction

      function void check_byte(logic [RSP_DATA_W-1:0] data, logic user, logic tlast);
         packed_byte_type want;
         if (pending_bytes.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual data %0h user %0b",
                     $time, data, user);
            errors++;
            return;
         end
         want = pending_bytes.pop_front();
         compare_field("data_byte", want.data_byte, data[7:0]);
         compare_field("byte_valid", want.byte_valid, user);
         compare_field("pad_bits", want.pad_bits, data[10:8]);
         compare_field("last", want.is_last, tlast);
      endfunction
   endclass

   logic                  clock = 1'b0;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata;
   logic [CMD_W-1:0]      req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tuser;
   logic                  rsp_tlast;

   packed_byte_tracker tracker;
   bit                 idle_on;
   bit                 hold_req;
   int                 quiet_cycles;

   bit_stream_packer_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // monitor both streams and watch for a hang
   always @(posedge clock) begin
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            tracker.note_command(cmd_type'(req_tuser), req_tdata[31:0], req_tdata[39:32]);
         end
         if (rsp_tvalid && rsp_tready) begin
            tracker.check_byte(rsp_tdata, rsp_tuser, rsp_tlast);
         end
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
            quiet_cycles <= 0;
         end else if (quiet_cycles + 1 >= WATCHDOG_LIMIT) begin
            $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
            $display("== FAIL ==");
            $finish;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
      end
   end

   // receiver: random stalls, one long hold on request
   initial begin
      rsp_tready = 1'b0;
      while (reset !== 1'b0) begin
         @(posedge clock);
      end
      forever begin
         if (hold_req) begin
            rsp_tready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_req = 1'b0;
         end else if (idle_on && $urandom_range(0, 3) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_tready <= 1'b1;
            @(posedge clock);
         end
      end
   end

   task automatic send_command(cmd_type cmd, logic [VALUE_W-1:0] value,
                               logic [COUNT_W-1:0] count);
      if (idle_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {count, value};
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic random_command(output cmd_type cmd, output logic [VALUE_W-1:0] value,
                                 output logic [COUNT_W-1:0] count);
      int pick;
      pick  = $urandom_range(0, 99);
      value = $urandom;
      if (pick < 55) begin
         cmd   = CMD_VALUE;
         count = ($urandom_range(0, 9) == 0) ? COUNT_W'($urandom_range(0, 255))
                                             : COUNT_W'($urandom_range(1, 32));
      end else if (pick < 80) begin
         cmd = CMD_RUN;
         if ($urandom_range(0, 1) == 0) begin
            value = '0;
         end
         count = ($urandom_range(0, 4) == 0) ? COUNT_W'($urandom_range(0, 255))
                                             : COUNT_W'($urandom_range(1, 40));
      end else if (pick < 93) begin
         cmd   = CMD_FLUSH;
         count = COUNT_W'($urandom);
      end else begin
         cmd   = CMD_CLOSE;
         count = COUNT_W'($urandom);
      end
   endtask

   initial begin
      cmd_type            cmd;
      logic [VALUE_W-1:0] value;
      logic [COUNT_W-1:0] count;

      tracker      = new();
      reset        = 1'b1;
      req_tvalid   = 1'b0;
      req_tdata    = '0;
      req_tuser    = '0;
      idle_on      = 1'b1;
      hold_req     = 1'b0;
      quiet_cycles = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      send_command(CMD_FLUSH, 32'h0000_0000, 8'd0);
      send_command(CMD_VALUE, 32'hFFFF_FFFF, 8'd32);
      send_command(CMD_VALUE, 32'hFFFF_FFFF, 8'd0);
      send_command(CMD_VALUE, 32'h0000_00A5, 8'd3);
      send_command(CMD_FLUSH, 32'hFFFF_FFFF, 8'd255);
      send_command(CMD_CLOSE, 32'h0000_0000, 8'd0);
      send_command(CMD_RUN,   32'h0000_0001, 8'd255);
      send_command(CMD_CLOSE, 32'h0000_0000, 8'd0);
      send_command(CMD_RUN,   32'h0000_0000, 8'd0);
      send_command(CMD_RUN,   32'h8000_0000, 8'd9);
      send_command(CMD_VALUE, 32'h1234_5678, 8'd255);
      send_command(CMD_VALUE, 32'hDEAD_BEEF, 8'd33);
      send_command(CMD_RUN,   32'h0000_0000, 8'd254);
      send_command(CMD_VALUE, 32'h0000_0000, 8'd32);
      send_command(CMD_VALUE, 32'h0000_FFFF, 8'd1);
      send_command(CMD_FLUSH, 32'h0000_0000, 8'd0);
      send_command(CMD_RUN,   32'h0000_0001, 8'd8);
      send_command(CMD_RUN,   32'hFFFF_FFFF, 8'd7);
      send_command(CMD_CLOSE, 32'h0000_0000, 8'd0);
      send_command(CMD_VALUE, 32'h5555_AAAA, 8'd17);
      send_command(CMD_FLUSH, 32'h0000_0000, 8'd0);
      send_command(CMD_FLUSH, 32'h0000_0000, 8'd0);

      for (int i = 0; i < RANDOM_COMMANDS; i++) begin
         idle_on = (i < 120) || (i >= 160 && i < 260);
         if (i == 200) begin
            hold_req = 1'b1;
         end
         random_command(cmd, value, count);
         send_command(cmd, value, count);
      end
      req_tvalid <= 1'b0;

      while (tracker.pending_bytes.size() != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (tracker.errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
